// ----- hdl/glos_pkg.sv -----
package glos_pkg;

    // map size and fixed-point format
    localparam int MAP_DIM    = 16;
    localparam int FRAC_BITS  = 8;

    // fixed field widths of the ports
    localparam int COORD_W    = 12;
    localparam int TILE_IN_W  = 4;
    localparam int OUT_TILE_W = 4;

    // derived widths
    localparam int TIW        = COORD_W - FRAC_BITS;
    localparam int MAP_W      = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
    localparam int ADDR_W     = 2 * MAP_W;
    localparam int WALK_W     = ((TIW > MAP_W + 1) ? TIW : MAP_W + 1) + 1;
    localparam int STEP_LIMIT = 2 * MAP_DIM;
    localparam int CNT_W      = $clog2(STEP_LIMIT + 1);
    localparam int DIST_W     = FRAC_BITS + $clog2(STEP_LIMIT + 2);
    localparam int PROD_W     = DIST_W + COORD_W;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // map port request from the control side
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_wall;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } map_req_t;

    // query points handed to the walker
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } query_t;

    // walk answer
    typedef struct packed {
        logic                  visible;
        logic [OUT_TILE_W-1:0] stop_x;
        logic [OUT_TILE_W-1:0] stop_y;
    } walk_res_t;

endpackage

// ----- hdl/glos_map.sv -----
module glos_map
(
    input  logic                clk,
    input  logic                rst_n,
    input  glos_pkg::map_req_t  req,
    output logic                rd_wall,
    output logic                clearing
);

    logic                        mem [2**glos_pkg::ADDR_W];
    logic                        rd_data_reg;
    logic [glos_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [glos_pkg::ADDR_W-1:0] clr_cnt_next;
    logic                        clr_busy_reg;
    logic                        clr_busy_next;
    logic                        we;
    logic [glos_pkg::ADDR_W-1:0] waddr;
    logic                        wdata;

    // clearing sweep after reset, one tile a cycle
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + glos_pkg::ADDR_W'(1);
            if (clr_cnt_reg == {glos_pkg::ADDR_W{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // write port shared by the sweep and tile writes
    always_comb
    begin
        if (clr_busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = 1'b0;
        end
        else
        begin
            we    = req.wr_en;
            waddr = req.wr_addr;
            wdata = req.wr_wall;
        end
    end

    // wall map memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_wall  = rd_data_reg;
    assign clearing = clr_busy_reg;

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.wr_en)
        else $error("tile write during clearing sweep");

    a_no_read_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.rd_en)
        else $error("map read during clearing sweep");

    a_sweep_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing sweep restarted without reset");

endmodule

// ----- hdl/glos_walk.sv -----
module glos_walk
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  glos_pkg::query_t             query,
    input  logic                         rd_wall,
    output logic                         rd_en,
    output logic [glos_pkg::ADDR_W-1:0]  rd_addr,
    output logic                         busy,
    output logic                         res_valid,
    output glos_pkg::walk_res_t          res,
    input  logic                         res_take
);

    typedef enum logic [2:0]
    {
        WK_IDLE  = 3'b001,
        WK_SETUP = 3'b010,
        WK_STEP  = 3'b100
    } walk_state_t;

    walk_state_t state_reg, state_next;

    logic [glos_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                                first_reg, first_next;

    logic signed [glos_pkg::WALK_W-1:0]  walk_x_reg, walk_x_next;
    logic signed [glos_pkg::WALK_W-1:0]  walk_y_reg, walk_y_next;
    logic [glos_pkg::TIW-1:0]            end_x_reg, end_x_next;
    logic [glos_pkg::TIW-1:0]            end_y_reg, end_y_next;
    logic [glos_pkg::COORD_W-1:0]        adx_reg, adx_next;
    logic [glos_pkg::COORD_W-1:0]        ady_reg, ady_next;
    logic                                neg_x_reg, neg_x_next;
    logic                                neg_y_reg, neg_y_next;
    logic [glos_pkg::FRAC_BITS:0]        dfx_reg, dfx_next;
    logic [glos_pkg::FRAC_BITS:0]        dfy_reg, dfy_next;
    logic [glos_pkg::PROD_W-1:0]         px_reg, px_next;
    logic [glos_pkg::PROD_W-1:0]         py_reg, py_next;

    logic [glos_pkg::FRAC_BITS:0]        one_fx;
    logic [glos_pkg::FRAC_BITS+glos_pkg::COORD_W:0] prod_x;
    logic [glos_pkg::FRAC_BITS+glos_pkg::COORD_W:0] prod_y;
    logic [glos_pkg::PROD_W-1:0]         inc_x;
    logic [glos_pkg::PROD_W-1:0]         inc_y;
    logic                                outside;
    logic                                at_end;
    logic                                hit;
    logic                                limit;
    logic                                finish;
    logic                                step_x;

    function automatic logic in_map(input logic signed [glos_pkg::WALK_W-1:0] w);
        in_map = !w[glos_pkg::WALK_W-1] &&
                 (w[glos_pkg::WALK_W-2:0] < (glos_pkg::WALK_W-1)'(glos_pkg::MAP_DIM));
    endfunction

    assign one_fx = {1'b1, {glos_pkg::FRAC_BITS{1'b0}}};

    // initial border distances scaled by the opposite delta
    assign prod_x = dfx_reg * ady_reg;
    assign prod_y = dfy_reg * adx_reg;

    // per-step growth of the scaled distances
    assign inc_x = glos_pkg::PROD_W'({ady_reg, {glos_pkg::FRAC_BITS{1'b0}}});
    assign inc_y = glos_pkg::PROD_W'({adx_reg, {glos_pkg::FRAC_BITS{1'b0}}});

    // tile checks for the tile just entered
    assign outside = !in_map(walk_x_reg) || !in_map(walk_y_reg);
    assign at_end  = (walk_x_reg == glos_pkg::WALK_W'(end_x_reg)) &&
                     (walk_y_reg == glos_pkg::WALK_W'(end_y_reg));
    assign hit     = !first_reg && rd_wall;
    assign limit   = (cnt_reg == glos_pkg::CNT_W'(glos_pkg::STEP_LIMIT));
    assign finish  = outside || at_end || hit || limit;
    assign step_x  = (px_reg < py_reg);

    // walker sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        end_x_next  = end_x_reg;
        end_y_next  = end_y_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        dfx_next    = dfx_reg;
        dfy_next    = dfy_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        rd_en       = 1'b0;
        unique case (state_reg)
            WK_IDLE:
            begin
                if (start)
                begin
                    walk_x_next = glos_pkg::WALK_W'(
                        query.start_x[glos_pkg::COORD_W-1:glos_pkg::FRAC_BITS]);
                    walk_y_next = glos_pkg::WALK_W'(
                        query.start_y[glos_pkg::COORD_W-1:glos_pkg::FRAC_BITS]);
                    end_x_next  = query.end_x[glos_pkg::COORD_W-1:glos_pkg::FRAC_BITS];
                    end_y_next  = query.end_y[glos_pkg::COORD_W-1:glos_pkg::FRAC_BITS];
                    if (query.end_x < query.start_x)
                    begin
                        adx_next   = query.start_x - query.end_x;
                        neg_x_next = 1'b1;
                        dfx_next   = {1'b0, query.start_x[glos_pkg::FRAC_BITS-1:0]};
                    end
                    else
                    begin
                        adx_next   = query.end_x - query.start_x;
                        neg_x_next = 1'b0;
                        dfx_next   = one_fx - {1'b0, query.start_x[glos_pkg::FRAC_BITS-1:0]};
                    end
                    if (query.end_y < query.start_y)
                    begin
                        ady_next   = query.start_y - query.end_y;
                        neg_y_next = 1'b1;
                        dfy_next   = {1'b0, query.start_y[glos_pkg::FRAC_BITS-1:0]};
                    end
                    else
                    begin
                        ady_next   = query.end_y - query.start_y;
                        neg_y_next = 1'b0;
                        dfy_next   = one_fx - {1'b0, query.start_y[glos_pkg::FRAC_BITS-1:0]};
                    end
                    cnt_next   = '0;
                    first_next = 1'b1;
                    state_next = WK_SETUP;
                end
            end
            WK_SETUP:
            begin
                px_next    = glos_pkg::PROD_W'(prod_x);
                py_next    = glos_pkg::PROD_W'(prod_y);
                state_next = WK_STEP;
            end
            WK_STEP:
            begin
                if (finish)
                begin
                    if (res_take)
                    begin
                        state_next = WK_IDLE;
                    end
                end
                else
                begin
                    // advance one tile on the axis with the nearer border
                    if (step_x)
                    begin
                        walk_x_next = neg_x_reg ? walk_x_reg - glos_pkg::WALK_W'(1)
                                                : walk_x_reg + glos_pkg::WALK_W'(1);
                        px_next     = px_reg + inc_x;
                    end
                    else
                    begin
                        walk_y_next = neg_y_reg ? walk_y_reg - glos_pkg::WALK_W'(1)
                                                : walk_y_reg + glos_pkg::WALK_W'(1);
                        py_next     = py_reg + inc_y;
                    end
                    rd_en      = 1'b1;
                    cnt_next   = cnt_reg + glos_pkg::CNT_W'(1);
                    first_next = 1'b0;
                end
            end
            default:
            begin
                state_next = WK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WK_IDLE;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        walk_x_reg <= walk_x_next;
        walk_y_reg <= walk_y_next;
        end_x_reg  <= end_x_next;
        end_y_reg  <= end_y_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        dfx_reg    <= dfx_next;
        dfy_reg    <= dfy_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
    end

    // map read for the tile being entered
    assign rd_addr = {walk_y_next[glos_pkg::MAP_W-1:0], walk_x_next[glos_pkg::MAP_W-1:0]};

    assign busy        = (state_reg != WK_IDLE);
    assign res_valid   = (state_reg == WK_STEP) && finish;
    assign res.visible = !outside && at_end;
    assign res.stop_x  = glos_pkg::OUT_TILE_W'(walk_x_reg);
    assign res.stop_y  = glos_pkg::OUT_TILE_W'(walk_y_reg);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == WK_IDLE))
        else $error("query started while walker busy");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WK_STEP) |-> (cnt_reg <= glos_pkg::CNT_W'(glos_pkg::STEP_LIMIT)))
        else $error("step count beyond limit");

    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WK_STEP && !finish) |=>
        ((walk_x_reg != $past(walk_x_reg)) != (walk_y_reg != $past(walk_y_reg))))
        else $error("step did not move exactly one axis");

    a_held_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res)))
        else $error("held answer changed");

endmodule

// ----- hdl/grid_line_of_sight.sv -----
// grid_line_of_sight: line-of-sight test over a square map of wall tiles
// input channel (in_valid / in_stall): kind 0 writes one wall bit at
//   tile_x, tile_y; kind 1 asks whether end_x, end_y is seen from
//   start_x, start_y (tile units, 8 fraction bits)
// output channel (out_valid / out_stall): one beat per query, none per
//   write: visible, and the tile where the walk stopped
// a write goes into the wall map as its beat is taken; a query's answer
//   reaches the output register after a setup state and a walk over n
//   tiles (at most 2*MAP_DIM, so 32); the next input beat is taken after that
// the walk enters one tile a cycle, bounded by the single wall map read port
// after reset the wall map is swept clear, all 256 tiles of the map
//   memory, and in_stall is high meanwhile
// while a result waits under out_stall, writes are still taken; a further
//   query is walked but holds its answer until the output register frees
module grid_line_of_sight
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [glos_pkg::TILE_IN_W-1:0]   tile_x,
    input  logic [glos_pkg::TILE_IN_W-1:0]   tile_y,
    input  logic                             tile_wall,
    input  logic [glos_pkg::COORD_W-1:0]     start_x,
    input  logic [glos_pkg::COORD_W-1:0]     start_y,
    input  logic [glos_pkg::COORD_W-1:0]     end_x,
    input  logic [glos_pkg::COORD_W-1:0]     end_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             visible,
    output logic [glos_pkg::OUT_TILE_W-1:0]  stop_x,
    output logic [glos_pkg::OUT_TILE_W-1:0]  stop_y
);

    glos_pkg::map_req_t   map_req;
    glos_pkg::query_t     query;
    glos_pkg::walk_res_t  res;
    glos_pkg::walk_res_t  out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 rd_wall;
    logic                 clearing;
    logic                 walk_busy;
    logic                 rd_en;
    logic [glos_pkg::ADDR_W-1:0] rd_addr;
    logic                 res_valid;
    logic                 res_take;
    logic                 in_accept;
    logic                 tile_in_map;

    // input beat handling
    assign in_stall    = clearing || walk_busy;
    assign in_accept   = in_valid && !in_stall;
    assign tile_in_map = (32'(tile_x) < 32'(glos_pkg::MAP_DIM)) &&
                         (32'(tile_y) < 32'(glos_pkg::MAP_DIM));

    assign query.start_x = start_x;
    assign query.start_y = start_y;
    assign query.end_x   = end_x;
    assign query.end_y   = end_y;

    // map port request
    assign map_req.wr_en   = in_accept && (kind == glos_pkg::KIND_WRITE) && tile_in_map;
    assign map_req.wr_addr = {glos_pkg::MAP_W'(tile_y), glos_pkg::MAP_W'(tile_x)};
    assign map_req.wr_wall = tile_wall;
    assign map_req.rd_en   = rd_en;
    assign map_req.rd_addr = rd_addr;

    glos_map u_map
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (map_req),
        .rd_wall  (rd_wall),
        .clearing (clearing)
    );

    glos_walk u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept && (kind == glos_pkg::KIND_QUERY)),
        .query     (query),
        .rd_wall   (rd_wall),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .busy      (walk_busy),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // output register
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = out_reg.visible;
    assign stop_x    = out_reg.stop_x;
    assign stop_y    = out_reg.stop_y;

endmodule
